FILE: hdl/ttwc_pkg.sv
// shared constants and types for the trajectory time window clipper
`timescale 1ns / 1ps

package ttwc_pkg;

    localparam int TIME_BITS    = 32;
    localparam int COORD_BITS   = 32;
    localparam int INDEX_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;

    // magnitude of a coordinate difference and the quotient need one extra bit
    localparam int QUOT_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = QUOT_BITS + TIME_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_BEGIN = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_END   = 1'b1;

    typedef struct packed {
        logic                         start;
        logic signed [COORD_BITS-1:0] p0;
        logic signed [COORD_BITS-1:0] p1;
        logic        [TIME_BITS-1:0]  off;
        logic        [TIME_BITS-1:0]  len;
    } md_req_t;

    typedef struct packed {
        logic                         done;
        logic signed [COORD_BITS-1:0] value;
    } md_rsp_t;

endpackage

FILE: hdl/ttwc_if.sv
// waypoint and segment stream interfaces
`timescale 1ns / 1ps

interface ttwc_point_if
    import ttwc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         path_start;
    logic        [INDEX_BITS-1:0] point_index;
    logic        [TIME_BITS-1:0]  point_time;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, path_start, point_index, point_time, point_x, point_y,
                    input ready);
    modport sink   (input valid, path_start, point_index, point_time, point_x, point_y,
                    output ready);
endinterface

interface ttwc_seg_if
    import ttwc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic        [INDEX_BITS-1:0] seg_start_index;
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic                         seg_clipped;
    logic                         seg_final;

    modport source (output valid, seg_start_index, seg_start_x, seg_start_y, seg_end_x,
                    seg_end_y, seg_clipped, seg_final,
                    input ready);
    modport sink   (input valid, seg_start_index, seg_start_x, seg_start_y, seg_end_x,
                    seg_end_y, seg_clipped, seg_final,
                    output ready);
endinterface

FILE: hdl/ttwc_muldiv.sv
// shared interpolation unit: p0 + trunc((p1 - p0) * off / len), split multiply and bit-serial divide
`timescale 1ns / 1ps

module ttwc_muldiv
    import ttwc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    localparam int OFF_LO_BITS = TIME_BITS / 2;
    localparam int OFF_HI_BITS = TIME_BITS - OFF_LO_BITS;
    localparam int CNT_BITS    = $clog2(QUOT_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MLO,
        S_MHI,
        S_ADD,
        S_DIV,
        S_FIN
    } state_t;

    state_t                          state_reg;
    logic                            neg_reg;
    logic [QUOT_BITS-1:0]            mag_reg;
    logic signed [COORD_BITS-1:0]    p0_reg;
    logic [TIME_BITS-1:0]            off_reg;
    logic [TIME_BITS-1:0]            len_reg;
    logic [PROD_BITS-1:0]            prod_reg;
    logic [QUOT_BITS+OFF_HI_BITS-1:0] pp_reg;
    logic [TIME_BITS-1:0]            rem_reg;
    logic [QUOT_BITS-1:0]            dvd_reg;
    logic [CNT_BITS-1:0]             cnt_reg;
    logic                            done_reg;
    logic signed [COORD_BITS-1:0]    value_reg;

    logic [QUOT_BITS-1:0]             diff;
    logic [QUOT_BITS-1:0]             mag_in;
    logic [QUOT_BITS+OFF_LO_BITS-1:0] lo_prod;
    logic [QUOT_BITS+OFF_HI_BITS-1:0] hi_prod;
    logic [PROD_BITS-1:0]             prod_sum;
    logic [TIME_BITS:0]               trial;
    logic [TIME_BITS:0]               trial_sub;
    logic                             trial_ge;
    logic [QUOT_BITS-1:0]             p0_ext;
    logic [QUOT_BITS-1:0]             interp;

    assign diff    = {req.p1[COORD_BITS-1], req.p1} - {req.p0[COORD_BITS-1], req.p0};
    assign mag_in  = diff[QUOT_BITS-1] ? (~diff + 1'b1) : diff;
    assign lo_prod = {{OFF_LO_BITS{1'b0}}, mag_reg}
                   * {{QUOT_BITS{1'b0}}, off_reg[OFF_LO_BITS-1:0]};
    assign hi_prod = {{OFF_HI_BITS{1'b0}}, mag_reg}
                   * {{QUOT_BITS{1'b0}}, off_reg[TIME_BITS-1:OFF_LO_BITS]};
    assign prod_sum = prod_reg + {pp_reg, {OFF_LO_BITS{1'b0}}};

    assign trial     = {rem_reg, dvd_reg[QUOT_BITS-1]};
    assign trial_ge  = trial >= {1'b0, len_reg};
    assign trial_sub = trial - {1'b0, len_reg};

    assign p0_ext = {p0_reg[COORD_BITS-1], p0_reg};
    assign interp = neg_reg ? (p0_ext - dvd_reg) : (p0_ext + dvd_reg);

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            p0_reg    <= '0;
            off_reg   <= '0;
            len_reg   <= '0;
            prod_reg  <= '0;
            pp_reg    <= '0;
            rem_reg   <= '0;
            dvd_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg   <= diff[QUOT_BITS-1];
                        mag_reg   <= mag_in;
                        p0_reg    <= req.p0;
                        off_reg   <= req.off;
                        len_reg   <= req.len;
                        state_reg <= S_MLO;
                    end
                end
                S_MLO:
                begin
                    prod_reg  <= {{OFF_HI_BITS{1'b0}}, lo_prod};
                    state_reg <= S_MHI;
                end
                S_MHI:
                begin
                    pp_reg    <= hi_prod;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    // quotient fits the low bits, so the top bits start below len
                    rem_reg   <= prod_sum[PROD_BITS-1 -: TIME_BITS];
                    dvd_reg   <= prod_sum[QUOT_BITS-1:0];
                    cnt_reg   <= CNT_BITS'(QUOT_BITS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= trial_ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
                    dvd_reg <= {dvd_reg[QUOT_BITS-2:0], trial_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    value_reg <= interp[COORD_BITS-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/trajectory_time_window_clip.sv
// top level: clips each segment of a timed 2-D polyline to the configured time window
`timescale 1ns / 1ps

// Each waypoint request closes a segment from the kept waypoint to the new one. A first
// waypoint or an ignored waypoint after the path stopped is taken in S_IDLE alone, a
// segment that misses the window passes S_CHECK back to S_IDLE, and a segment wholly
// inside the window passes S_CHECK and S_EMIT to reach the output register. A clipped
// segment runs four interpolations one after another on the single shared multiply/divide
// unit, each through issue, split multiply and add, one quotient bit per cycle, then result
// and handback. Points are not taken while a segment is in progress; a finished segment
// waits in the output register while the next point is taken.

module trajectory_time_window_clip
    import ttwc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]    cfg_data,
    ttwc_point_if.sink              points,
    ttwc_seg_if.source              segments
);

    localparam int NUM_RES = 4;
    localparam int K_BITS  = $clog2(NUM_RES);
    localparam logic [K_BITS-1:0] K_LAST = K_BITS'(NUM_RES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t                       state_reg;
    logic [TIME_BITS-1:0]         win_begin_reg;
    logic [TIME_BITS-1:0]         win_end_reg;
    logic [TIME_BITS-1:0]         prev_time_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic [INDEX_BITS-1:0]        prev_index_reg;
    logic                         have_prev_reg;
    logic                         path_done_reg;
    logic [TIME_BITS-1:0]         t0_reg;
    logic [TIME_BITS-1:0]         t1_reg;
    logic [TIME_BITS-1:0]         tb_reg;
    logic [TIME_BITS-1:0]         te_reg;
    logic                         whole_reg;
    logic                         final_reg;
    logic [INDEX_BITS-1:0]        seg_index_reg;
    logic signed [COORD_BITS-1:0] p0_reg [2];
    logic signed [COORD_BITS-1:0] p1_reg [2];
    logic [TIME_BITS-1:0]         off_b_reg;
    logic [TIME_BITS-1:0]         off_e_reg;
    logic [TIME_BITS-1:0]         len_reg;
    logic signed [COORD_BITS-1:0] res_reg [NUM_RES];
    logic [K_BITS-1:0]            k_reg;
    logic                         out_valid_reg;
    logic [INDEX_BITS-1:0]        out_index_reg;
    logic signed [COORD_BITS-1:0] out_sx_reg;
    logic signed [COORD_BITS-1:0] out_sy_reg;
    logic signed [COORD_BITS-1:0] out_ex_reg;
    logic signed [COORD_BITS-1:0] out_ey_reg;
    logic                         out_clipped_reg;
    logic                         out_final_reg;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic                 accept;
    logic                 have_eff;
    logic                 done_eff;
    logic                 final_in;
    logic                 whole_in;
    logic [TIME_BITS-1:0] tb_in;
    logic [TIME_BITS-1:0] te_in;

    assign points.ready = (state_reg == S_IDLE);
    assign accept       = points.valid && points.ready;

    assign have_eff = have_prev_reg && !points.path_start;
    assign done_eff = path_done_reg && !points.path_start;
    assign final_in = points.point_time >= win_end_reg;
    assign whole_in = (prev_time_reg >= win_begin_reg) && (points.point_time <= win_end_reg);
    assign tb_in    = (prev_time_reg > win_begin_reg) ? prev_time_reg : win_begin_reg;
    assign te_in    = (points.point_time < win_end_reg) ? points.point_time : win_end_reg;

    assign md_req.start = (state_reg == S_ISSUE);
    assign md_req.p0    = p0_reg[k_reg[0]];
    assign md_req.p1    = p1_reg[k_reg[0]];
    assign md_req.off   = k_reg[1] ? off_e_reg : off_b_reg;
    assign md_req.len   = len_reg;

    assign segments.valid           = out_valid_reg;
    assign segments.seg_start_index = out_index_reg;
    assign segments.seg_start_x     = out_sx_reg;
    assign segments.seg_start_y     = out_sy_reg;
    assign segments.seg_end_x       = out_ex_reg;
    assign segments.seg_end_y       = out_ey_reg;
    assign segments.seg_clipped     = out_clipped_reg;
    assign segments.seg_final       = out_final_reg;

    ttwc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_begin_reg <= '0;
            win_end_reg   <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_BEGIN: win_begin_reg <= cfg_data;
                CFG_WINDOW_END:   win_end_reg   <= cfg_data;
                default:          win_end_reg   <= win_end_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prev_time_reg   <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_index_reg  <= '0;
            have_prev_reg   <= 1'b0;
            path_done_reg   <= 1'b0;
            t0_reg          <= '0;
            t1_reg          <= '0;
            tb_reg          <= '0;
            te_reg          <= '0;
            whole_reg       <= 1'b0;
            final_reg       <= 1'b0;
            seg_index_reg   <= '0;
            p0_reg          <= '{default: '0};
            p1_reg          <= '{default: '0};
            off_b_reg       <= '0;
            off_e_reg       <= '0;
            len_reg         <= '0;
            res_reg         <= '{default: '0};
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
            out_index_reg   <= '0;
            out_sx_reg      <= '0;
            out_sy_reg      <= '0;
            out_ex_reg      <= '0;
            out_ey_reg      <= '0;
            out_clipped_reg <= 1'b0;
            out_final_reg   <= 1'b0;
        end
        else
        begin
            if (segments.valid && segments.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        path_done_reg <= done_eff;
                        if (!done_eff)
                        begin
                            prev_time_reg  <= points.point_time;
                            prev_x_reg     <= points.point_x;
                            prev_y_reg     <= points.point_y;
                            prev_index_reg <= points.point_index;
                            have_prev_reg  <= 1'b1;
                            if (have_eff)
                            begin
                                path_done_reg <= final_in;
                                t0_reg        <= prev_time_reg;
                                t1_reg        <= points.point_time;
                                tb_reg        <= tb_in;
                                te_reg        <= te_in;
                                whole_reg     <= whole_in;
                                final_reg     <= final_in;
                                seg_index_reg <= prev_index_reg;
                                p0_reg[0]     <= prev_x_reg;
                                p0_reg[1]     <= prev_y_reg;
                                p1_reg[0]     <= points.point_x;
                                p1_reg[1]     <= points.point_y;
                                res_reg[0]    <= prev_x_reg;
                                res_reg[1]    <= prev_y_reg;
                                res_reg[2]    <= points.point_x;
                                res_reg[3]    <= points.point_y;
                                state_reg     <= S_CHECK;
                            end
                        end
                        else
                        begin
                            have_prev_reg <= have_prev_reg;
                        end
                    end
                end
                S_CHECK:
                begin
                    off_b_reg <= tb_reg - t0_reg;
                    off_e_reg <= te_reg - t0_reg;
                    len_reg   <= t1_reg - t0_reg;
                    k_reg     <= '0;
                    if (whole_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (tb_reg < te_reg)
                    begin
                        state_reg <= S_ISSUE;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (md_rsp.done)
                    begin
                        res_reg[k_reg] <= md_rsp.value;
                        k_reg          <= k_reg + 1'b1;
                        state_reg      <= (k_reg == K_LAST) ? S_EMIT : S_ISSUE;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_index_reg   <= seg_index_reg;
                        out_sx_reg      <= res_reg[0];
                        out_sy_reg      <= res_reg[1];
                        out_ex_reg      <= res_reg[2];
                        out_ey_reg      <= res_reg[3];
                        out_clipped_reg <= !whole_reg;
                        out_final_reg   <= final_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/ttwc_checker.sv
// port-level checks for the trajectory time window clipper, bound to the top level
`timescale 1ns / 1ps

module ttwc_checker
    import ttwc_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic        [INDEX_BITS-1:0] out_index,
    input logic signed [COORD_BITS-1:0] out_sx,
    input logic signed [COORD_BITS-1:0] out_sy,
    input logic signed [COORD_BITS-1:0] out_ex,
    input logic signed [COORD_BITS-1:0] out_ey,
    input logic                         out_clipped,
    input logic                         out_final
);

    // stalled segment holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_sx)
            && $stable(out_sy) && $stable(out_ex) && $stable(out_ey)
            && $stable(out_clipped) && $stable(out_final))
        else $error("segment changed while stalled");

    // single output register: a taken segment leaves it empty in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("segment register refilled in the cycle it was taken");

    // ready only drops after a point request was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("ready dropped without a request");

    // a segment is loaded only while point requests are held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("segment appeared while idle");

endmodule

bind trajectory_time_window_clip ttwc_checker u_ttwc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (points.valid),
    .in_ready    (points.ready),
    .out_valid   (segments.valid),
    .out_ready   (segments.ready),
    .out_index   (segments.seg_start_index),
    .out_sx      (segments.seg_start_x),
    .out_sy      (segments.seg_start_y),
    .out_ex      (segments.seg_end_x),
    .out_ey      (segments.seg_end_y),
    .out_clipped (segments.seg_clipped),
    .out_final   (segments.seg_final)
);
